@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file rcrp_checker.sv.
// Needs a clk and an active low rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/rcrp_pkg.sv @@
// Types, character codes and field schedules of the record parser.
// No dependencies; used by rcrp_core and radio_channel_record_parser.
package rcrp_pkg;

    localparam int CALL_CHARS = 8;
    localparam logic [4:0] FO_FIELDS = 5'd21;
    localparam logic [4:0] ME_FIELDS = 5'd23;
    localparam logic [33:0] FREQ_MAX = 34'd9999999999;

    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;

    localparam logic ITEM_FIELD  = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_ERROR    = 1'b1;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_FIELDS,
        PH_SWALLOW
    } phase_t;

    typedef enum logic [1:0] {
        SK_DEC,
        SK_STEP,
        SK_CALL
    } slot_kind_t;

    typedef struct packed {
        slot_kind_t  kind;
        logic [3:0]  width;
        logic [33:0] limit;
    } slot_t;

    typedef struct packed {
        logic        item_kind;
        logic        record_kind;
        logic [4:0]  field_number;
        logic [63:0] field_value;
        logic [3:0]  field_length;
        logic        status;
        logic        last_of_record;
    } item_t;

    typedef struct packed {
        logic [1:0] n;
        item_t      a;
        item_t      b;
    } emit_t;

    function automatic slot_t mk_slot(slot_kind_t k, logic [3:0] w, logic [33:0] lim);
        slot_t s;
        s.kind  = k;
        s.width = w;
        s.limit = lim;
        return s;
    endfunction

    function automatic slot_t sched_slot(logic me, logic [4:0] idx);
        slot_t s;
        s = mk_slot(SK_DEC, 4'd1, 34'd0);
        if (!me)
        begin
            case (idx)
                5'd0:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd1:  s = mk_slot(SK_DEC, 4'd10, FREQ_MAX);
                5'd2:  s = mk_slot(SK_DEC, 4'd10, FREQ_MAX);
                5'd3:  s = mk_slot(SK_STEP, 4'd1, 34'd11);
                5'd4:  s = mk_slot(SK_STEP, 4'd1, 34'd11);
                5'd5:  s = mk_slot(SK_DEC, 4'd1, 34'd9);
                5'd6:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd7:  s = mk_slot(SK_DEC, 4'd1, 34'd3);
                5'd8:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd9:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd10: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd11: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd12: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd13: s = mk_slot(SK_DEC, 4'd1, 34'd3);
                5'd14: s = mk_slot(SK_DEC, 4'd2, 34'd41);
                5'd15: s = mk_slot(SK_DEC, 4'd2, 34'd41);
                5'd16: s = mk_slot(SK_DEC, 4'd3, 34'd103);
                5'd17: s = mk_slot(SK_DEC, 4'd1, 34'd3);
                5'd18: s = mk_slot(SK_CALL, 4'd0, 34'd0);
                5'd19: s = mk_slot(SK_DEC, 4'd1, 34'd2);
                5'd20: s = mk_slot(SK_DEC, 4'd2, 34'd99);
                default: s = mk_slot(SK_DEC, 4'd1, 34'd0);
            endcase
        end
        else
        begin
            case (idx)
                5'd0:  s = mk_slot(SK_DEC, 4'd3, 34'd999);
                5'd1:  s = mk_slot(SK_DEC, 4'd10, FREQ_MAX);
                5'd2:  s = mk_slot(SK_DEC, 4'd10, FREQ_MAX);
                5'd3:  s = mk_slot(SK_STEP, 4'd1, 34'd11);
                5'd4:  s = mk_slot(SK_STEP, 4'd1, 34'd11);
                5'd5:  s = mk_slot(SK_DEC, 4'd1, 34'd9);
                5'd6:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd7:  s = mk_slot(SK_DEC, 4'd1, 34'd3);
                5'd8:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd9:  s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd10: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd11: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd12: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd13: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                5'd14: s = mk_slot(SK_DEC, 4'd1, 34'd3);
                5'd15: s = mk_slot(SK_DEC, 4'd2, 34'd41);
                5'd16: s = mk_slot(SK_DEC, 4'd2, 34'd41);
                5'd17: s = mk_slot(SK_DEC, 4'd3, 34'd103);
                5'd18: s = mk_slot(SK_DEC, 4'd1, 34'd3);
                5'd19: s = mk_slot(SK_CALL, 4'd0, 34'd0);
                5'd20: s = mk_slot(SK_DEC, 4'd1, 34'd2);
                5'd21: s = mk_slot(SK_DEC, 4'd2, 34'd99);
                5'd22: s = mk_slot(SK_DEC, 4'd1, 34'd1);
                default: s = mk_slot(SK_DEC, 4'd1, 34'd0);
            endcase
        end
        return s;
    endfunction

endpackage

@@ hdl/rcrp_core.sv @@
// Parse state and per-byte field logic of the record parser.
// Depends on rcrp_pkg; instantiated by radio_channel_record_parser.
module rcrp_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output rcrp_pkg::emit_t emit
);

    rcrp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic        kind_reg, kind_next;
    logic [4:0]  fidx_reg, fidx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [33:0] acc_reg, acc_next;
    logic [63:0] call_reg, call_next;

    rcrp_pkg::slot_t slot;
    logic        final_f;
    logic        is_comma;
    logic        skip;
    logic        is_digit;
    logic [3:0]  digit;
    logic        take_ok;
    logic [33:0] acc_t;
    logic [63:0] call_t;
    logic [3:0]  cnt_t;
    logic [33:0] cl_acc;
    logic [63:0] cl_call;
    logic [3:0]  cl_cnt;
    logic        close_ok;
    logic [63:0] close_val;
    logic        pre_bad;
    logic        f_bad;
    logic        comma_ok;
    logic        last_ok;
    logic        bad;
    logic        fld_emit;

    // evaluation of the byte against the current field
    always_comb
    begin
        slot     = rcrp_pkg::sched_slot(kind_reg, fidx_reg);
        final_f  = fidx_reg == (kind_reg ? rcrp_pkg::ME_FIELDS - 5'd1
                                         : rcrp_pkg::FO_FIELDS - 5'd1);
        is_comma = data_byte == rcrp_pkg::CH_COMMA;
        skip     = last_byte && (data_byte == rcrp_pkg::CH_CR);
        is_digit = (data_byte >= rcrp_pkg::CH_0) && (data_byte <= rcrp_pkg::CH_9);
        digit    = data_byte[3:0];
        cnt_t    = cnt_reg + 4'd1;
        acc_t    = acc_reg;
        call_t   = call_reg;
        take_ok  = 1'b0;
        case (slot.kind)
            rcrp_pkg::SK_DEC:
            begin
                take_ok = is_digit && (cnt_reg < slot.width);
                acc_t   = (acc_reg << 3) + (acc_reg << 1) + {30'd0, digit};
            end
            rcrp_pkg::SK_STEP:
            begin
                take_ok = (cnt_reg == 4'd0) && (is_digit || data_byte == rcrp_pkg::CH_A
                                                || data_byte == rcrp_pkg::CH_B);
                if (is_digit)
                    acc_t = {30'd0, digit};
                else if (data_byte == rcrp_pkg::CH_B)
                    acc_t = 34'd11;
                else
                    acc_t = 34'd10;
            end
            rcrp_pkg::SK_CALL:
            begin
                take_ok = (data_byte != rcrp_pkg::CH_NUL) && (data_byte != rcrp_pkg::CH_CR)
                          && (data_byte != rcrp_pkg::CH_LF)
                          && (cnt_reg < 4'(rcrp_pkg::CALL_CHARS));
                call_t  = {call_reg[55:0], data_byte};
            end
            default:
                take_ok = 1'b0;
        endcase

        if (is_comma || skip)
        begin
            cl_acc  = acc_reg;
            cl_call = call_reg;
            cl_cnt  = cnt_reg;
        end
        else
        begin
            cl_acc  = (slot.kind == rcrp_pkg::SK_CALL) ? acc_reg : acc_t;
            cl_call = (slot.kind == rcrp_pkg::SK_CALL) ? call_t : call_reg;
            cl_cnt  = cnt_t;
        end

        case (slot.kind)
            rcrp_pkg::SK_DEC:
            begin
                close_ok  = (cl_cnt == slot.width) && (cl_acc <= slot.limit);
                close_val = {30'd0, cl_acc};
            end
            rcrp_pkg::SK_STEP:
            begin
                close_ok  = cl_cnt == 4'd1;
                close_val = {30'd0, cl_acc};
            end
            rcrp_pkg::SK_CALL:
            begin
                close_ok  = 1'b1;
                close_val = cl_call;
            end
            default:
            begin
                close_ok  = 1'b0;
                close_val = 64'd0;
            end
        endcase

        case (pos_reg)
            2'd0:    pre_bad = (data_byte != rcrp_pkg::CH_F) && (data_byte != rcrp_pkg::CH_M);
            2'd1:    pre_bad = data_byte != (kind_reg ? rcrp_pkg::CH_E : rcrp_pkg::CH_O);
            default: pre_bad = data_byte != rcrp_pkg::CH_SPACE;
        endcase

        f_bad    = !skip && (is_comma ? (final_f || !close_ok) : !take_ok);
        comma_ok = is_comma && !f_bad;
        // a comma on the final byte leaves an empty field, never valid
        last_ok  = !f_bad && last_byte && !is_comma && final_f && close_ok;

        bad      = 1'b1;
        fld_emit = 1'b0;
        case (phase_reg)
            rcrp_pkg::PH_PREFIX:
                bad = pre_bad || last_byte;
            rcrp_pkg::PH_FIELDS:
            begin
                bad      = f_bad || (last_byte && !last_ok);
                fld_emit = comma_ok || last_ok;
            end
            default:
                bad = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        fidx_next  = fidx_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        call_next  = call_reg;
        case (phase_reg)
            rcrp_pkg::PH_PREFIX:
            begin
                if (!pre_bad)
                begin
                    if (pos_reg == 2'd0)
                        kind_next = data_byte == rcrp_pkg::CH_M;
                    if (pos_reg == 2'd2)
                    begin
                        phase_next = rcrp_pkg::PH_FIELDS;
                        fidx_next  = 5'd0;
                        cnt_next   = 4'd0;
                        acc_next   = 34'd0;
                        call_next  = 64'd0;
                    end
                    else
                        pos_next = pos_reg + 2'd1;
                end
                if (bad)
                    phase_next = rcrp_pkg::PH_SWALLOW;
            end
            rcrp_pkg::PH_FIELDS:
            begin
                if (comma_ok)
                begin
                    fidx_next = fidx_reg + 5'd1;
                    cnt_next  = 4'd0;
                    acc_next  = 34'd0;
                    call_next = 64'd0;
                end
                else if (!skip && !is_comma && take_ok)
                begin
                    cnt_next = cnt_t;
                    if (slot.kind == rcrp_pkg::SK_CALL)
                        call_next = call_t;
                    else
                        acc_next = acc_t;
                end
                if (bad)
                    phase_next = rcrp_pkg::PH_SWALLOW;
            end
            default:
                phase_next = phase_reg;
        endcase
        if (last_byte)
        begin
            phase_next = rcrp_pkg::PH_PREFIX;
            pos_next   = 2'd0;
            fidx_next  = 5'd0;
            cnt_next   = 4'd0;
            acc_next   = 34'd0;
            call_next  = 64'd0;
        end
    end

    // result items
    always_comb
    begin
        rcrp_pkg::item_t fld;
        rcrp_pkg::item_t sts;
        fld.item_kind      = rcrp_pkg::ITEM_FIELD;
        fld.record_kind    = kind_reg;
        fld.field_number   = fidx_reg;
        fld.field_value    = close_val;
        fld.field_length   = cl_cnt;
        fld.status         = rcrp_pkg::ST_OK;
        fld.last_of_record = 1'b0;
        sts.item_kind      = rcrp_pkg::ITEM_STATUS;
        sts.record_kind    = kind_next;
        sts.field_number   = 5'd0;
        sts.field_value    = 64'd0;
        sts.field_length   = 4'd0;
        sts.status         = bad ? rcrp_pkg::ST_ERROR : rcrp_pkg::ST_OK;
        sts.last_of_record = 1'b1;
        emit.a = fld_emit ? fld : sts;
        emit.b = sts;
        emit.n = step ? ({1'b0, fld_emit} + {1'b0, last_byte}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rcrp_pkg::PH_PREFIX;
            pos_reg   <= 2'd0;
            kind_reg  <= 1'b0;
            fidx_reg  <= 5'd0;
            cnt_reg   <= 4'd0;
            acc_reg   <= 34'd0;
            call_reg  <= 64'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            fidx_reg  <= fidx_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            call_reg  <= call_next;
        end
    end

endmodule

@@ hdl/radio_channel_record_parser.sv @@
// Top level of the radio channel record parser: input register, parse core,
// four-entry result queue. Depends on rcrp_pkg and rcrp_core.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   in      | in_valid  | in_stall  | data_byte, last_byte
//   out     | out_valid | out_stall | item_kind ... last_of_record (7 fields)
//
// One byte per cycle while in_stall is low; a byte's results are queued from the input
// register when the core steps on it, and leave the queue at one per cycle while
// out_stall is low. The end-of-record byte can give a field and a status.
// Input stalls only when the result queue holds three or more items.
// Reset returns the parser to waiting for a record prefix, queue empty.
module radio_channel_record_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic        record_kind,
    output logic [4:0]  field_number,
    output logic [63:0] field_value,
    output logic [3:0]  field_length,
    output logic        status,
    output logic        last_of_record
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        room;
    logic        step;
    logic        pop;
    rcrp_pkg::emit_t emit;

    rcrp_pkg::item_t q_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    rcrp_pkg::item_t head;

    assign room     = count_reg <= 3'd2;
    assign in_stall = in_valid_reg && !room;
    assign step     = in_valid_reg && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    rcrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .emit      (emit)
    );

    assign out_valid   = count_reg != 3'd0;
    assign pop         = out_valid && !out_stall;
    assign wr_ptr_next = wr_ptr_reg + emit.n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, emit.n} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.n != 2'd0)
            q_reg[wr_ptr_reg] <= emit.a;
        if (emit.n == 2'd2)
            q_reg[wr_ptr_reg + 2'd1] <= emit.b;
    end

    assign head           = q_reg[rd_ptr_reg];
    assign item_kind      = head.item_kind;
    assign record_kind    = head.record_kind;
    assign field_number   = head.field_number;
    assign field_value    = head.field_value;
    assign field_length   = head.field_length;
    assign status         = head.status;
    assign last_of_record = head.last_of_record;

endmodule

@@ hdl/rcrp_checker.sv @@
// Port-level checks on radio_channel_record_parser, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rcrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic        item_kind,
    input logic        record_kind,
    input logic [4:0]  field_number,
    input logic [63:0] field_value,
    input logic [3:0]  field_length,
    input logic        status,
    input logic        last_of_record
);

    logic [76:0] out_item;
    logic        field_shape_ok;
    logic        status_shape_ok;

    assign out_item        = {item_kind, record_kind, field_number, field_value,
                              field_length, status, last_of_record};
    assign field_shape_ok  = !status && !last_of_record && (field_number <= 5'd22)
                             && (field_length <= 4'd10);
    assign status_shape_ok = last_of_record && (field_number == 5'd0)
                             && (field_value == 64'd0) && (field_length == 4'd0);

    `CHK_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable({data_byte, last_byte}))
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `CHK_NEXT(a_out_value_hold, out_valid && out_stall, $stable(out_item))
    `CHK_SAME(a_field_shape, out_valid && !item_kind, field_shape_ok)
    `CHK_SAME(a_status_shape, out_valid && item_kind, status_shape_ok)

endmodule

bind radio_channel_record_parser rcrp_checker u_rcrp_checker (.*);

@@ bench/tb_radio_channel_record_parser.sv @@
// Testbench for radio_channel_record_parser: builds FO/ME reply records, predicts field
// and status items per accepted byte and checks every output request against them.
// Depends on rcrp_pkg and the radio_channel_record_parser RTL.
`timescale 1ns / 1ps

module tb_radio_channel_record_parser;

    typedef enum int {
        MUT_NONE,
        MUT_FIELD,
        MUT_TRUNC,
        MUT_EXTRA,
        MUT_PREFIX,
        MUT_NOISE,
        MUT_INSERT,
        MUT_MIDCR
    } mut_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_MIN
    } fill_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       drain;
    } req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        item_kind;
    logic        record_kind;
    logic [4:0]  field_number;
    logic [63:0] field_value;
    logic [3:0]  field_length;
    logic        status;
    logic        last_of_record;

    req_t            byte_q[$];
    rcrp_pkg::item_t want_q[$];
    logic [7:0]      rec_buf[$];
    req_t            cur;
    rcrp_pkg::item_t got;
    rcrp_pkg::item_t want;

    int          n_taken = 0;
    int          n_total = 0;
    int          n_mismatch = 0;
    int          hold_left = 0;
    int          hold_at = 0;
    bit          hold_done = 1'b0;

    // parser state
    rcrp_pkg::phase_t ph;
    logic [1:0]  pre_pos;
    logic        rec_me;
    logic [4:0]  fld_idx;
    logic [3:0]  n_chars;
    logic [33:0] acc;
    logic [63:0] call_sh;

    radio_channel_record_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .record_kind    (record_kind),
        .field_number   (field_number),
        .field_value    (field_value),
        .field_length   (field_length),
        .status         (status),
        .last_of_record (last_of_record)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic rcrp_pkg::slot_t fmt(rcrp_pkg::slot_kind_t k, logic [3:0] w,
                                            logic [33:0] lim);
        rcrp_pkg::slot_t s;
        s.kind  = k;
        s.width = w;
        s.limit = lim;
        return s;
    endfunction

    function automatic rcrp_pkg::slot_t fo_format(logic [4:0] i);
        case (i)
            5'd0, 5'd6, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12:
                return fmt(rcrp_pkg::SK_DEC, 4'd1, 34'd1);
            5'd1, 5'd2:
                return fmt(rcrp_pkg::SK_DEC, 4'd10, rcrp_pkg::FREQ_MAX);
            5'd3, 5'd4:
                return fmt(rcrp_pkg::SK_STEP, 4'd1, 34'd11);
            5'd5:
                return fmt(rcrp_pkg::SK_DEC, 4'd1, 34'd9);
            5'd7, 5'd13, 5'd17:
                return fmt(rcrp_pkg::SK_DEC, 4'd1, 34'd3);
            5'd14, 5'd15:
                return fmt(rcrp_pkg::SK_DEC, 4'd2, 34'd41);
            5'd16:
                return fmt(rcrp_pkg::SK_DEC, 4'd3, 34'd103);
            5'd18:
                return fmt(rcrp_pkg::SK_CALL, 4'd0, 34'd0);
            5'd19:
                return fmt(rcrp_pkg::SK_DEC, 4'd1, 34'd2);
            5'd20:
                return fmt(rcrp_pkg::SK_DEC, 4'd2, 34'd99);
            default:
                return fmt(rcrp_pkg::SK_DEC, 4'd1, 34'd0);
        endcase
    endfunction

    // ME: own channel field, extra flag at 13 and at the end, rest shifted FO layout
    function automatic rcrp_pkg::slot_t field_format(logic me, logic [4:0] i);
        if (!me)
            return fo_format(i);
        if (i == 5'd0)
            return fmt(rcrp_pkg::SK_DEC, 4'd3, 34'd999);
        if (i == 5'd13 || i == 5'd22)
            return fmt(rcrp_pkg::SK_DEC, 4'd1, 34'd1);
        if (i >= 5'd14)
            return fo_format(i - 5'd1);
        return fo_format(i);
    endfunction

    function automatic void clear_field();
        n_chars = 4'd0;
        acc = 34'd0;
        call_sh = 64'd0;
    endfunction

    function automatic void restart();
        ph = rcrp_pkg::PH_PREFIX;
        pre_pos = 2'd0;
        fld_idx = 5'd0;
        clear_field();
    endfunction

    function automatic bit take_char(rcrp_pkg::slot_t s, logic [7:0] c);
        case (s.kind)
            rcrp_pkg::SK_DEC:
            begin
                if (c < rcrp_pkg::CH_0 || c > rcrp_pkg::CH_9 || n_chars >= s.width)
                    return 1'b0;
                acc = acc * 34'd10 + 34'(c - rcrp_pkg::CH_0);
            end
            rcrp_pkg::SK_STEP:
            begin
                if (n_chars >= 4'd1)
                    return 1'b0;
                if (c >= rcrp_pkg::CH_0 && c <= rcrp_pkg::CH_9)
                    acc = 34'(c - rcrp_pkg::CH_0);
                else if (c == rcrp_pkg::CH_A || c == rcrp_pkg::CH_B)
                    acc = 34'd10 + 34'(c - rcrp_pkg::CH_A);
                else
                    return 1'b0;
            end
            default:
            begin
                if (c == rcrp_pkg::CH_NUL || c == rcrp_pkg::CH_CR || c == rcrp_pkg::CH_LF
                    || n_chars >= rcrp_pkg::CALL_CHARS)
                    return 1'b0;
                call_sh = {call_sh[55:0], c};
            end
        endcase
        n_chars = n_chars + 4'd1;
        return 1'b1;
    endfunction

    function automatic bit close_field(rcrp_pkg::slot_t s, output rcrp_pkg::item_t it);
        logic [63:0] v;
        it = '0;
        case (s.kind)
            rcrp_pkg::SK_DEC:
            begin
                if (n_chars != s.width || acc > s.limit)
                    return 1'b0;
                v = 64'(acc);
            end
            rcrp_pkg::SK_STEP:
            begin
                if (n_chars != 4'd1)
                    return 1'b0;
                v = 64'(acc);
            end
            default:
                v = call_sh;
        endcase
        it.item_kind      = rcrp_pkg::ITEM_FIELD;
        it.record_kind    = rec_me;
        it.field_number   = fld_idx;
        it.field_value    = v;
        it.field_length   = n_chars;
        it.status         = rcrp_pkg::ST_OK;
        it.last_of_record = 1'b0;
        return 1'b1;
    endfunction

    // expected items caused by one accepted byte
    function automatic void parse_byte(logic [7:0] c, logic lst);
        rcrp_pkg::slot_t s;
        logic [4:0]      cnt;
        logic [4:0]      fi;
        logic            fin;
        logic            bad;
        rcrp_pkg::item_t it;
        bad = 1'b0;
        case (ph)
            rcrp_pkg::PH_PREFIX:
            begin
                if (pre_pos == 2'd0)
                begin
                    if (c == rcrp_pkg::CH_F)
                        rec_me = 1'b0;
                    else if (c == rcrp_pkg::CH_M)
                        rec_me = 1'b1;
                    else
                        bad = 1'b1;
                end
                else if (pre_pos == 2'd1)
                begin
                    if (c != (rec_me ? rcrp_pkg::CH_E : rcrp_pkg::CH_O))
                        bad = 1'b1;
                end
                else if (c != rcrp_pkg::CH_SPACE)
                    bad = 1'b1;
                if (!bad)
                begin
                    if (pre_pos >= 2'd2)
                    begin
                        ph = rcrp_pkg::PH_FIELDS;
                        fld_idx = 5'd0;
                        clear_field();
                    end
                    else
                        pre_pos = pre_pos + 2'd1;
                end
                if (lst)
                    bad = 1'b1;
                if (bad)
                    ph = rcrp_pkg::PH_SWALLOW;
            end
            rcrp_pkg::PH_FIELDS:
            begin
                cnt = rec_me ? rcrp_pkg::ME_FIELDS : rcrp_pkg::FO_FIELDS;
                fi = (fld_idx < cnt) ? fld_idx : cnt - 5'd1;
                s = field_format(rec_me, fi);
                fin = (fi + 5'd1) == cnt;
                if (!(lst && c == rcrp_pkg::CH_CR))
                begin
                    if (c == rcrp_pkg::CH_COMMA)
                    begin
                        if (fin || !close_field(s, it))
                            bad = 1'b1;
                        else
                        begin
                            want_q.push_back(it);
                            fld_idx = fi + 5'd1;
                            clear_field();
                            fi = fld_idx;
                            s = field_format(rec_me, fi);
                            fin = (fi + 5'd1) == cnt;
                        end
                    end
                    else if (!take_char(s, c))
                        bad = 1'b1;
                end
                if (!bad && lst)
                begin
                    if (fin && close_field(s, it))
                        want_q.push_back(it);
                    else
                        bad = 1'b1;
                end
                if (bad)
                    ph = rcrp_pkg::PH_SWALLOW;
            end
            default:
                bad = 1'b1;
        endcase
        if (lst)
        begin
            it = '0;
            it.item_kind      = rcrp_pkg::ITEM_STATUS;
            it.record_kind    = rec_me;
            it.status         = bad ? rcrp_pkg::ST_ERROR : rcrp_pkg::ST_OK;
            it.last_of_record = 1'b1;
            want_q.push_back(it);
            restart();
        end
    endfunction

    function automatic logic [7:0] call_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == rcrp_pkg::CH_CR || c == rcrp_pkg::CH_LF || c == rcrp_pkg::CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] other_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= rcrp_pkg::CH_0 && c <= rcrp_pkg::CH_9) || c == rcrp_pkg::CH_A
               || c == rcrp_pkg::CH_B || c == rcrp_pkg::CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] step_char(int k);
        return (k < 10) ? rcrp_pkg::CH_0 + 8'(k) : rcrp_pkg::CH_A + 8'(k - 10);
    endfunction

    function automatic logic [7:0] rand_digit();
        return rcrp_pkg::CH_0 + 8'($urandom_range(9));
    endfunction

    task automatic push_dec(input longint unsigned v, input int w);
        logic [7:0] d [0:9];
        int k;
        for (k = 0; k < w; k++)
        begin
            d[k] = rcrp_pkg::CH_0 + 8'(v % 10);
            v = v / 10;
        end
        for (k = w - 1; k >= 0; k--)
            rec_buf.push_back(d[k]);
    endtask

    task automatic append_field(input rcrp_pkg::slot_t s, input fill_t fill);
        fill_t eff;
        int    r;
        int    k;
        int    n;
        eff = fill;
        r = $urandom_range(7);
        if (fill == FILL_RANDOM && r == 0)
            eff = FILL_MAX;
        else if (fill == FILL_RANDOM && r == 1)
            eff = FILL_MIN;
        case (s.kind)
            rcrp_pkg::SK_DEC:
            begin
                if (s.width == 4'd10)
                begin
                    for (k = 0; k < 10; k++)
                        rec_buf.push_back(eff == FILL_MAX ? rcrp_pkg::CH_9 :
                                          eff == FILL_MIN ? rcrp_pkg::CH_0 : rand_digit());
                end
                else if (eff == FILL_MAX)
                    push_dec(s.limit, s.width);
                else if (eff == FILL_MIN)
                    push_dec(0, s.width);
                else
                    push_dec($urandom_range(32'(s.limit)), s.width);
            end
            rcrp_pkg::SK_STEP:
            begin
                k = (eff == FILL_MAX) ? 11 : (eff == FILL_MIN) ? 0 : $urandom_range(11);
                rec_buf.push_back(step_char(k));
            end
            default:
            begin
                n = (eff == FILL_MAX) ? rcrp_pkg::CALL_CHARS : (eff == FILL_MIN) ? 0 :
                    $urandom_range(rcrp_pkg::CALL_CHARS);
                for (k = 0; k < n; k++)
                    rec_buf.push_back(eff == FILL_MAX ? 8'hFF : call_char());
            end
        endcase
    endtask

    task automatic append_bad_field(input rcrp_pkg::slot_t s);
        int               r;
        int               k;
        int               n;
        int               pos;
        longint unsigned  top;
        logic [7:0]       ctl;
        r = $urandom_range(3);
        case (s.kind)
            rcrp_pkg::SK_DEC:
            begin
                top = 1;
                for (k = 0; k < s.width; k++)
                    top = top * 10;
                top = top - 1;
                if (r == 3 && s.limit < top)
                    push_dec(s.limit + 1 + $urandom_range(32'(top - s.limit - 1)), s.width);
                else
                begin
                    n = (r == 1) ? s.width - 1 : (r == 2) ? s.width : s.width + 1;
                    pos = (r == 2) ? $urandom_range(n - 1) : -1;
                    for (k = 0; k < n; k++)
                        rec_buf.push_back(k == pos ? other_char() : rand_digit());
                end
            end
            rcrp_pkg::SK_STEP:
            begin
                if (r == 1)
                begin
                    rec_buf.push_back(step_char($urandom_range(11)));
                    rec_buf.push_back(step_char($urandom_range(11)));
                end
                else if (r != 0)
                    rec_buf.push_back(other_char());
            end
            default:
            begin
                if (r == 0)
                begin
                    n = $urandom_range(rcrp_pkg::CALL_CHARS + 1, rcrp_pkg::CALL_CHARS + 2);
                    for (k = 0; k < n; k++)
                        rec_buf.push_back(call_char());
                end
                else
                begin
                    n = $urandom_range(1, rcrp_pkg::CALL_CHARS);
                    pos = $urandom_range(n - 1);
                    ctl = (r == 1) ? rcrp_pkg::CH_NUL :
                          (r == 2) ? rcrp_pkg::CH_CR : rcrp_pkg::CH_LF;
                    for (k = 0; k < n; k++)
                        rec_buf.push_back(k == pos ? ctl : call_char());
                end
            end
        endcase
    endtask

    task automatic queue_buf(input logic drain);
        req_t r;
        int   i;
        for (i = 0; i < rec_buf.size(); i++)
        begin
            r.ch    = rec_buf[i];
            r.lst   = (i == rec_buf.size() - 1);
            r.drain = drain && (i == 0);
            byte_q.push_back(r);
        end
    endtask

    task automatic add_raw(input string txt);
        int k;
        rec_buf.delete();
        for (k = 0; k < txt.len(); k++)
            rec_buf.push_back(txt[k]);
        queue_buf(1'b0);
    endtask

    task automatic add_record(input mut_t mut, input logic me, input fill_t fill,
                              input logic with_cr, input logic drain);
        int              cnt;
        int              i;
        int              n;
        int              bad_i;
        int              pos;
        rcrp_pkg::slot_t s;
        rec_buf.delete();
        rec_buf.push_back(me ? rcrp_pkg::CH_M : rcrp_pkg::CH_F);
        rec_buf.push_back(me ? rcrp_pkg::CH_E : rcrp_pkg::CH_O);
        rec_buf.push_back(rcrp_pkg::CH_SPACE);
        cnt = me ? 23 : 21;
        bad_i = $urandom_range(cnt - 1);
        for (i = 0; i < cnt; i++)
        begin
            if (i > 0)
                rec_buf.push_back(rcrp_pkg::CH_COMMA);
            s = field_format(me, 5'(i));
            if (mut == MUT_FIELD && i == bad_i)
                append_bad_field(s);
            else
                append_field(s, fill);
        end
        if (mut == MUT_EXTRA)
        begin
            rec_buf.push_back(rcrp_pkg::CH_COMMA);
            rec_buf.push_back(rand_digit());
        end
        if (with_cr)
            rec_buf.push_back(rcrp_pkg::CH_CR);
        case (mut)
            MUT_TRUNC:
                rec_buf = rec_buf[0:$urandom_range(rec_buf.size() - 2)];
            MUT_PREFIX:
            begin
                pos = $urandom_range(2);
                rec_buf[pos] = 8'($urandom_range(255));
            end
            MUT_NOISE:
            begin
                rec_buf.delete();
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++)
                    rec_buf.push_back(8'($urandom_range(255)));
            end
            MUT_INSERT:
            begin
                pos = $urandom_range(3, rec_buf.size() - 1);
                rec_buf.insert(pos, 8'($urandom_range(255)));
            end
            MUT_MIDCR:
            begin
                pos = $urandom_range(3, rec_buf.size() - 2);
                rec_buf.insert(pos, rcrp_pkg::CH_CR);
            end
            default:
                ;
        endcase
        queue_buf(drain);
    endtask

    function automatic int idle_mode();
        if (n_taken * 3 < n_total)
            return 0;
        if (n_taken * 3 < n_total * 2)
            return 1;
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_mode())
            0:       return 12;
            1:       return 65;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_mode())
            0:       return 65;
            1:       return 12;
            default: return 0;
        endcase
    endfunction

    // input requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(data_byte, last_byte);
                n_taken <= n_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_q.size() != 0 && !(byte_q[0].drain && want_q.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct())
                begin
                    cur = byte_q.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= cur.ch;
                    last_byte <= cur.lst;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the result queue fills and the input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_total != 0 && n_taken >= hold_at)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct());
    end

    // output requests
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got.item_kind      = item_kind;
            got.record_kind    = record_kind;
            got.field_number   = field_number;
            got.field_value    = field_value;
            got.field_length   = field_length;
            got.status         = status;
            got.last_of_record = last_of_record;
            if (want_q.size() == 0)
            begin
                if (n_mismatch < 10)
                    $display({"unexpected item: kind=%0d rec=%0d num=%0d val=%h",
                              " len=%0d st=%0d last=%0d"},
                             got.item_kind, got.record_kind, got.field_number,
                             got.field_value, got.field_length, got.status,
                             got.last_of_record);
                n_mismatch++;
            end
            else
            begin
                want = want_q.pop_front();
                if (got !== want)
                begin
                    if (n_mismatch < 10)
                    begin
                        $display({"mismatch want: kind=%0d rec=%0d num=%0d val=%h",
                                  " len=%0d st=%0d last=%0d"},
                                 want.item_kind, want.record_kind, want.field_number,
                                 want.field_value, want.field_length, want.status,
                                 want.last_of_record);
                        $display({"          got: kind=%0d rec=%0d num=%0d val=%h",
                                  " len=%0d st=%0d last=%0d"},
                                 got.item_kind, got.record_kind, got.field_number,
                                 got.field_value, got.field_length, got.status,
                                 got.last_of_record);
                    end
                    n_mismatch++;
                end
            end
        end
    end

    initial
    begin
        int   r;
        mut_t m;
        rec_me = 1'b0;
        restart();

        add_record(MUT_NONE, 1'b0, FILL_MAX, 1'b0, 1'b1);
        add_record(MUT_NONE, 1'b1, FILL_MIN, 1'b1, 1'b0);
        add_record(MUT_NONE, 1'b1, FILL_MAX, 1'b1, 1'b0);
        add_record(MUT_NONE, 1'b0, FILL_MIN, 1'b0, 1'b0);
        add_raw("XO 1");
        add_raw("FE 1");
        add_raw("MO ");
        add_raw("ME!");
        add_raw("F");
        add_raw("FO ");
        add_raw("\r");
        add_raw("FO \r");
        add_record(MUT_EXTRA, 1'b1, FILL_RANDOM, 1'b0, 1'b0);
        add_record(MUT_TRUNC, 1'b0, FILL_RANDOM, 1'b0, 1'b0);
        add_record(MUT_MIDCR, 1'b0, FILL_RANDOM, 1'b1, 1'b0);
        add_record(MUT_FIELD, 1'b1, FILL_RANDOM, 1'b0, 1'b0);

        while (byte_q.size() < 1100)
        begin
            r = $urandom_range(99);
            m = (r < 70) ? MUT_NONE : (r < 76) ? MUT_FIELD : (r < 81) ? MUT_TRUNC :
                (r < 85) ? MUT_EXTRA : (r < 89) ? MUT_PREFIX : (r < 93) ? MUT_NOISE :
                (r < 97) ? MUT_INSERT : MUT_MIDCR;
            add_record(m, 1'($urandom_range(1)), FILL_RANDOM, 1'($urandom_range(1)),
                       $urandom_range(7) == 0);
        end
        n_total = byte_q.size();
        hold_at = n_total * 5 / 6;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (n_taken < n_total || want_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_mismatch == 0 && want_q.size() == 0)
            $display("PASS radio_channel_record_parser");
        else
            $display("FAIL radio_channel_record_parser");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL radio_channel_record_parser");
        $finish;
    end

endmodule

@@ radio_channel_record_parser.f @@
+incdir+hdl
hdl/rcrp_pkg.sv
hdl/rcrp_core.sv
hdl/radio_channel_record_parser.sv
hdl/rcrp_checker.sv
bench/tb_radio_channel_record_parser.sv
